FILE: hw/rtl/brl_pkg.sv
// ----------------------------------------------------------------------------
// brl_pkg
// Shared constants, register codes and status types of the line rasterizer.
// ----------------------------------------------------------------------------
package brl_pkg;

  localparam int COORD_BITS_DEF = 6;
  localparam int ORIGIN_W       = 12;
  localparam int PIX_W          = 13;
  localparam int COLOR_W        = 24;
  localparam int APB_AW         = 3;
  localparam int APB_DW         = 32;
  localparam int Q_DEPTH        = 2;

  // Register index codes, decoded from paddr[2].
  localparam logic REG_ORIGIN_X = 1'b0;
  localparam logic REG_ORIGIN_Y = 1'b1;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic active;
    logic step;
    logic last;
  } bk_status_t;

endpackage

FILE: hw/rtl/brl_front.sv
// ----------------------------------------------------------------------------
// brl_front
// Accepts line items, drops empty lines and precomputes deltas, step
// directions and the initial error term for the walker.
// ----------------------------------------------------------------------------
module brl_front #(
  parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF,
  parameter int CMD_W      = 7 * COORD_BITS + 4 + brl_pkg::COLOR_W
) (
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [COORD_BITS-1:0]      start_x,
  input  logic [COORD_BITS-1:0]      start_y,
  input  logic [COORD_BITS-1:0]      end_x,
  input  logic [COORD_BITS-1:0]      end_y,
  input  logic [brl_pkg::COLOR_W-1:0] line_color,
  input  brl_pkg::q_status_t         q_status,
  output logic                       push,
  output logic [CMD_W-1:0]           cmd
);

  localparam int EW = COORD_BITS + 2;

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic                  sx_pos;
  logic                  sy_pos;
  logic signed [EW-1:0]  err0;

  always_comb begin
    sx_pos = start_x < end_x;
    sy_pos = start_y < end_y;
    dx     = (end_x > start_x) ? end_x - start_x : start_x - end_x;
    dy     = (end_y > start_y) ? end_y - start_y : start_y - end_y;
    if (dx > dy) begin
      err0 = signed'(EW'(dx >> 1));
    end else begin
      err0 = -signed'(EW'(dy >> 1));
    end
  end

  assign in_ready = !q_status.full;

  // A line whose endpoints coincide yields no pixels and never reaches the queue.
  assign push = in_valid && in_ready && ((start_x != end_x) || (start_y != end_y));

  assign cmd = {line_color, err0, sy_pos, sx_pos, dy, dx, end_y, end_x, start_y, start_x};

endmodule

FILE: hw/rtl/brl_queue.sv
// ----------------------------------------------------------------------------
// brl_queue
// Short FIFO of prepared line commands between front and walker.
// ----------------------------------------------------------------------------
module brl_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = brl_pkg::Q_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [WIDTH-1:0]   wdata,
  input  logic               pop,
  output logic [WIDTH-1:0]   rdata,
  output brl_pkg::q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r;
  logic [PW-1:0]    rd_ptr_nxt;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;

  assign status.full  = count_r == CW'(DEPTH);
  assign status.empty = count_r == '0;
  assign rdata        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: hw/rtl/brl_walker.sv
// ----------------------------------------------------------------------------
// brl_walker
// Walks one queued line with the combined-error scheme, one pixel per cycle
// while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module brl_walker #(
  parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF,
  parameter int CMD_W      = 7 * COORD_BITS + 4 + brl_pkg::COLOR_W
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  brl_pkg::q_status_t                  q_status,
  input  logic [CMD_W-1:0]                    cmd,
  output logic                                pop,
  input  logic signed [brl_pkg::ORIGIN_W-1:0] origin_x,
  input  logic signed [brl_pkg::ORIGIN_W-1:0] origin_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [brl_pkg::PIX_W-1:0]    pixel_x,
  output logic signed [brl_pkg::PIX_W-1:0]    pixel_y,
  output logic [brl_pkg::COLOR_W-1:0]         pixel_color,
  output logic                                last_pixel,
  output brl_pkg::bk_status_t                 status
);

  localparam int CB = COORD_BITS;
  localparam int EW = CB + 2;
  localparam int PW = brl_pkg::PIX_W;

  logic [CB-1:0]               x_r, y_r, ex_r, ey_r, dx_r, dy_r, n_r;
  logic                        sx_pos_r, sy_pos_r, active_r;
  logic signed [EW-1:0]        err_r;
  logic [brl_pkg::COLOR_W-1:0] color_r;

  logic [CB-1:0]               c_x, c_y, c_ex, c_ey, c_dx, c_dy;
  logic                        c_sx, c_sy;
  logic signed [EW-1:0]        c_err;
  logic [brl_pkg::COLOR_W-1:0] c_color;

  logic                        step;
  logic                        step_x, step_y, last;
  logic signed [EW-1:0]        dxs, dys, err_nxt;
  logic [CB-1:0]               x_nxt, y_nxt, n_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic signed [PW-1:0]        pixel_x_r, pixel_y_r;
  logic [brl_pkg::COLOR_W-1:0] pixel_color_r;
  logic                        last_pixel_r;

  assign {c_color, c_err, c_sy, c_sx, c_dy, c_dx, c_ey, c_ex, c_y, c_x} = cmd;

  assign pop  = !active_r && !q_status.empty;
  assign step = active_r && (!out_valid_r || out_ready);

  always_comb begin
    dxs     = signed'(EW'(dx_r));
    dys     = signed'(EW'(dy_r));
    step_x  = err_r > -dxs;
    step_y  = err_r < dys;
    err_nxt = err_r - (step_x ? dys : '0) + (step_y ? dxs : '0);
    x_nxt   = step_x ? (sx_pos_r ? x_r + 1'b1 : x_r - 1'b1) : x_r;
    y_nxt   = step_y ? (sy_pos_r ? y_r + 1'b1 : y_r - 1'b1) : y_r;
    n_nxt   = n_r + 1'b1;
    // The run is capped at 2^CB - 1 pixels; the capped pixel closes the run.
    last    = ((x_nxt == ex_r) && (y_nxt == ey_r)) || (n_nxt == '1);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        active_r <= 1'b1;
      end else if (step && last) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x_r      <= c_x;
      y_r      <= c_y;
      ex_r     <= c_ex;
      ey_r     <= c_ey;
      dx_r     <= c_dx;
      dy_r     <= c_dy;
      sx_pos_r <= c_sx;
      sy_pos_r <= c_sy;
      err_r    <= c_err;
      color_r  <= c_color;
      n_r      <= '0;
    end else if (step) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      err_r <= err_nxt;
      n_r   <= n_nxt;
    end
    if (step) begin
      pixel_x_r     <= PW'(origin_x) + PW'(x_r);
      pixel_y_r     <= PW'(origin_y) + PW'(y_r);
      pixel_color_r <= color_r;
      last_pixel_r  <= last;
    end
  end

  assign out_valid     = out_valid_r;
  assign pixel_x       = pixel_x_r;
  assign pixel_y       = pixel_y_r;
  assign pixel_color   = pixel_color_r;
  assign last_pixel    = last_pixel_r;
  assign status.active = active_r;
  assign status.step   = step;
  assign status.last   = last;

endmodule

FILE: hw/rtl/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer: line segment to pixel stream, one pixel per cycle
// while out_ready does not stall the output. A line passes the queue, the
// walker's run registers and the output register; the walker takes a new line
// only after the last pixel of a run, which is capped at 63 pixels.
// Synchronous active-low reset clears control state and both origins to 0.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer #(
  parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [brl_pkg::APB_AW-1:0]          paddr,
  input  logic [brl_pkg::APB_DW-1:0]          pwdata,
  output logic [brl_pkg::APB_DW-1:0]          prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [COORD_BITS-1:0]               in_start_x,
  input  logic [COORD_BITS-1:0]               in_start_y,
  input  logic [COORD_BITS-1:0]               in_end_x,
  input  logic [COORD_BITS-1:0]               in_end_y,
  input  logic [brl_pkg::COLOR_W-1:0]         in_line_color,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [brl_pkg::PIX_W-1:0]    out_pixel_x,
  output logic signed [brl_pkg::PIX_W-1:0]    out_pixel_y,
  output logic [brl_pkg::COLOR_W-1:0]         out_pixel_color,
  output logic                                out_last_pixel
);

  localparam int CMD_W = 7 * COORD_BITS + 4 + brl_pkg::COLOR_W;

  logic signed [brl_pkg::ORIGIN_W-1:0] origin_x_r, origin_y_r;
  logic                                cfg_wr;
  logic                                reg_sel;
  logic                                push, pop;
  logic [CMD_W-1:0]                    cmd_in, cmd_out;
  brl_pkg::q_status_t                  q_status;
  brl_pkg::bk_status_t                 bk_status;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        brl_pkg::REG_ORIGIN_X: origin_x_r <= pwdata[brl_pkg::ORIGIN_W-1:0];
        brl_pkg::REG_ORIGIN_Y: origin_y_r <= pwdata[brl_pkg::ORIGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      brl_pkg::REG_ORIGIN_X: prdata = brl_pkg::APB_DW'(origin_x_r);
      brl_pkg::REG_ORIGIN_Y: prdata = brl_pkg::APB_DW'(origin_y_r);
      default:               prdata = '0;
    endcase
  end

  brl_front #(
    .COORD_BITS (COORD_BITS),
    .CMD_W      (CMD_W)
  ) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .start_x    (in_start_x),
    .start_y    (in_start_y),
    .end_x      (in_end_x),
    .end_y      (in_end_y),
    .line_color (in_line_color),
    .q_status   (q_status),
    .push       (push),
    .cmd        (cmd_in)
  );

  brl_queue #(
    .WIDTH (CMD_W),
    .DEPTH (brl_pkg::Q_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wdata  (cmd_in),
    .pop    (pop),
    .rdata  (cmd_out),
    .status (q_status)
  );

  brl_walker #(
    .COORD_BITS (COORD_BITS),
    .CMD_W      (CMD_W)
  ) u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_status    (q_status),
    .cmd         (cmd_out),
    .pop         (pop),
    .origin_x    (origin_x_r),
    .origin_y    (origin_y_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_x     (out_pixel_x),
    .pixel_y     (out_pixel_y),
    .pixel_color (out_pixel_color),
    .last_pixel  (out_last_pixel),
    .status      (bk_status)
  );

`ifndef NO_ASSERTIONS
  // The queue can never look full and empty at the same time.
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  // The closing pixel of a run releases the walker.
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.step && bk_status.last |=> !bk_status.active)
    else $error("walker still busy after last pixel");

  // Any other pixel keeps the walker on the same line.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.step && !bk_status.last |=> bk_status.active && out_valid)
    else $error("walker stopped before last pixel");

  // A pixel marked last is only shown after a step that flagged it.
  a_last_origin: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.step |=> out_last_pixel == $past(bk_status.last))
    else $error("last mark does not follow walker");
`endif

endmodule

FILE: bench/tb_bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// tb_bresenham_line_rasterizer
// Self-checking bench for the line rasterizer. Line items go in on a
// valid/ready channel. A behavioral line walker predicts every pixel from the
// origins programmed over the register port. Each output item is compared
// field by field with the oldest predicted pixel. Directed lines, origin
// extremes, a long output hold-off and random lines are run in turn.
// ----------------------------------------------------------------------------
module tb_bresenham_line_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB             = brl_pkg::COORD_BITS_DEF;
  localparam int RUN_LIMIT      = (1 << CB) - 1;
  localparam int SETTLE_CYCLES  = 100;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_PRINTS     = 100;

  typedef struct {
    logic signed [brl_pkg::PIX_W-1:0] x;
    logic signed [brl_pkg::PIX_W-1:0] y;
    logic [brl_pkg::COLOR_W-1:0]      color;
    logic                             last;
  } pixel_t;

  logic                             clk;
  logic                             rst_n;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [brl_pkg::APB_AW-1:0]       paddr;
  logic [brl_pkg::APB_DW-1:0]       pwdata;
  logic [brl_pkg::APB_DW-1:0]       prdata;
  logic                             pready;
  logic                             in_valid;
  logic                             in_ready;
  logic [CB-1:0]                    in_start_x;
  logic [CB-1:0]                    in_start_y;
  logic [CB-1:0]                    in_end_x;
  logic [CB-1:0]                    in_end_y;
  logic [brl_pkg::COLOR_W-1:0]      in_line_color;
  logic                             out_valid;
  logic                             out_ready;
  logic signed [brl_pkg::PIX_W-1:0] out_pixel_x;
  logic signed [brl_pkg::PIX_W-1:0] out_pixel_y;
  logic [brl_pkg::COLOR_W-1:0]      out_pixel_color;
  logic                             out_last_pixel;

  pixel_t pixel_q[$];
  pixel_t exp_pix;
  int     org_x;
  int     org_y;
  int     err_count;
  bit     tx_idle_en;
  bit     rx_idle_en;
  int     stall_left;
  int     hold_cnt;
  int     quiet_cycles;

  bresenham_line_rasterizer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_line_color   (in_line_color),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_last_pixel  (out_last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    // Keep the log bounded when a systematic bug floods the output.
    if (err_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    err_count++;
  endtask

  // Walks one line with the combined error term and queues its pixels.
  task automatic predict_line(input logic [CB-1:0] sx, input logic [CB-1:0] sy,
                              input logic [CB-1:0] ex, input logic [CB-1:0] ey,
                              input logic [brl_pkg::COLOR_W-1:0] color);
    int x, y, tx, ty, dx, dy, step_x, step_y, err, e0, n;
    pixel_t p;
    x = sx;
    y = sy;
    tx = ex;
    ty = ey;
    dx = (tx > x) ? tx - x : x - tx;
    dy = (ty > y) ? ty - y : y - ty;
    step_x = (x < tx) ? 1 : -1;
    step_y = (y < ty) ? 1 : -1;
    err = (dx > dy) ? dx / 2 : -(dy / 2);
    n = 0;
    while ((x != tx || y != ty) && n < RUN_LIMIT) begin
      e0 = err;
      p.x = brl_pkg::PIX_W'(org_x + x);
      p.y = brl_pkg::PIX_W'(org_y + y);
      p.color = color;
      if (e0 > -dx) begin
        err -= dy;
        x += step_x;
      end
      if (e0 < dy) begin
        err += dx;
        y += step_y;
      end
      n++;
      p.last = ((x == tx && y == ty) || n == RUN_LIMIT);
      pixel_q.push_back(p);
    end
  endtask

  // Starts and ends at a falling edge; valid stays high when no gap is drawn.
  task automatic send_line(input logic [CB-1:0] sx, input logic [CB-1:0] sy,
                           input logic [CB-1:0] ex, input logic [CB-1:0] ey,
                           input logic [brl_pkg::COLOR_W-1:0] color);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_start_x    <= sx;
    in_start_y    <= sy;
    in_end_x      <= ex;
    in_end_y      <= ey;
    in_line_color <= color;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predict_line(sx, sy, ex, ey, color);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pixel_q.size() > 0) @(negedge clk);
    // Lines with equal endpoints leave no pixel behind and never reach the queue.
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_origin(input logic reg_sel, input int value);
    logic signed [brl_pkg::ORIGIN_W-1:0] v12;
    v12 = value[brl_pkg::ORIGIN_W-1:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    // Bits above the register width are don't-care and get random values.
    pwdata  <= {(brl_pkg::APB_DW - brl_pkg::ORIGIN_W)'($urandom()), v12};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (reg_sel == brl_pkg::REG_ORIGIN_X) begin
      org_x = v12;
    end else begin
      org_y = v12;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_origins(input int ox, input int oy);
    settle();
    write_origin(brl_pkg::REG_ORIGIN_X, ox);
    write_origin(brl_pkg::REG_ORIGIN_Y, oy);
  endtask

  task automatic test_directed_lines();
    logic [CB-1:0] hi;
    hi = '1;
    send_line(0, 0, 0, 0, 24'h000000);
    send_line(hi, hi, hi, hi, 24'hFFFFFF);
    send_line(0, 0, hi, hi, 24'hFFFFFF);
    send_line(hi, hi, 0, 0, 24'h000000);
    send_line(0, 0, hi, 0, 24'hA5A5A5);
    send_line(hi, 0, 0, 0, 24'h5A5A5A);
    send_line(0, 0, 0, hi, 24'h123456);
    send_line(0, hi, 0, 0, 24'hFEDCBA);
    send_line(0, hi, hi, 0, 24'h800001);
    send_line(hi, 0, 0, hi, 24'h7FFFFE);
    send_line(10, 10, 11, 10, 24'h00FF00);
    send_line(10, 10, 10, 9, 24'hFF0000);
    send_line(10, 10, 11, 11, 24'h0000FF);
    send_line(5, 7, 40, 20, 24'h0F0F0F);
    send_line(40, 20, 5, 7, 24'hF0F0F0);
    send_line(3, 2, 17, 60, 24'h111111);
    send_line(17, 60, 3, 2, 24'hEEEEEE);
    send_line(0, 0, hi, 1, 24'h010203);
    send_line(0, 0, 1, hi, 24'h0A0B0C);
    send_line(32, 32, 31, 33, 24'hCAFE00);
  endtask

  task automatic test_origin_extremes();
    int ox[4] = '{2047, -2048, 2047, -2048};
    int oy[4] = '{2047, -2048, -2048, 2047};
    logic [CB-1:0] hi;
    hi = '1;
    for (int i = 0; i < 4; i++) begin
      set_origins(ox[i], oy[i]);
      send_line(0, 0, hi, hi, brl_pkg::COLOR_W'($urandom()));
      send_line(hi, hi, 0, 0, brl_pkg::COLOR_W'($urandom()));
      send_line(hi, 0, 0, hi, brl_pkg::COLOR_W'($urandom()));
      send_line(0, hi, hi, hi, brl_pkg::COLOR_W'($urandom()));
    end
  endtask

  // The output side holds off while lines keep coming, so the input stalls.
  task automatic test_output_backpressure();
    logic [CB-1:0] hi;
    hi = '1;
    set_origins($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048);
    tx_idle_en = 1'b0;
    hold_cnt = HOLD_CYCLES;
    for (int i = 0; i < 12; i++) begin
      send_line(0, CB'($urandom()), hi, CB'($urandom()), brl_pkg::COLOR_W'($urandom()));
    end
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_lines();
    logic [CB-1:0] sx, sy, ex, ey;
    int kind;
    for (int phase = 0; phase < 5; phase++) begin
      set_origins($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048);
      tx_idle_en = (phase != 1) && (phase != 3);
      rx_idle_en = (phase != 1) && (phase != 2);
      for (int i = 0; i < 84; i++) begin
        sx = CB'($urandom());
        sy = CB'($urandom());
        ex = CB'($urandom());
        ey = CB'($urandom());
        kind = $urandom_range(0, 15);
        if (kind == 0) begin
          ex = sx;
          ey = sy;
        end else if (kind == 1) begin
          ex = sx + CB'($urandom_range(0, 6) - 3);
          ey = sy + CB'($urandom_range(0, 6) - 3);
        end else if (kind == 2) begin
          ex = sx;
        end else if (kind == 3) begin
          ey = sy;
        end
        send_line(sx, sy, ex, ey, brl_pkg::COLOR_W'($urandom()));
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Result checker; also draws the receiver's stall after each item.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pixel_q.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel x=%0d y=%0d",
                                  out_pixel_x, out_pixel_y));
      end else begin
        exp_pix = pixel_q.pop_front();
        if (out_pixel_x !== exp_pix.x) begin
          report_mismatch($sformatf("pixel_x got %0d want %0d", out_pixel_x, exp_pix.x));
        end
        if (out_pixel_y !== exp_pix.y) begin
          report_mismatch($sformatf("pixel_y got %0d want %0d", out_pixel_y, exp_pix.y));
        end
        if (out_pixel_color !== exp_pix.color) begin
          report_mismatch($sformatf("pixel_color got %h want %h",
                                    out_pixel_color, exp_pix.color));
        end
        if (out_last_pixel !== exp_pix.last) begin
          report_mismatch($sformatf("last_pixel got %b want %b at x=%0d y=%0d",
                                    out_last_pixel, exp_pix.last, exp_pix.x, exp_pix.y));
        end
      end
      stall_left = rx_idle_en ? $urandom_range(0, 15) : 0;
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        out_ready <= 1'b0;
        hold_cnt--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Ends the run when nothing moves on any port for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    in_start_x    = '0;
    in_start_y    = '0;
    in_end_x      = '0;
    in_end_y      = '0;
    in_line_color = '0;
    org_x         = 0;
    org_y         = 0;
    err_count     = 0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    stall_left    = 0;
    hold_cnt      = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_lines();
    test_origin_extremes();
    test_output_backpressure();
    test_random_lines();
    settle();

    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/brl_pkg.sv
hw/rtl/brl_front.sv
hw/rtl/brl_queue.sv
hw/rtl/brl_walker.sv
hw/rtl/bresenham_line_rasterizer.sv
bench/tb_bresenham_line_rasterizer.sv
